@@ rtl/core/wbsr_pkg.sv @@
// Shared types, constants and helper functions of the weighted blend refiner.
package wbsr_pkg;

  localparam int VAL_W      = 15;
  localparam int WGT_W      = 16;
  localparam int ITER_W     = 10;
  localparam int NUM_TGT    = 3;
  localparam int TOT_W      = 18;   // sum of three 16 bit weights
  localparam int PROD_W     = VAL_W + WGT_W;
  localparam int ACC_W      = 33;   // sum of three 31 bit products
  localparam int QUO_W      = 15;   // the blend never exceeds the largest target
  localparam int DVS_W      = TOT_W + QUO_W - 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SCHED_W    = 3;
  localparam int STEP_W     = 9;
  localparam int SCHED_LEN  = 7;
  localparam int CNT_W      = 10;

  localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(25500);

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_A   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_B   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_C   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT = 2'd3;

  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(NUM_TGT - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_STEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       clear;
    logic       mac;
    logic [1:0] sel;
    logic       div;
  } arith_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } refine_ctl_t;

  function automatic logic [VAL_W-1:0] sat_val(input logic [VAL_W-1:0] v);
    sat_val = (v > VAL_MAX) ? VAL_MAX : v;
  endfunction

  // Step schedule 1, 10, 100, 300, 100, 10, 1 in hundredths.
  function automatic logic [STEP_W-1:0] step_of(input logic [SCHED_W-1:0] idx);
    case (idx)
      3'd0:    step_of = STEP_W'(1);
      3'd1:    step_of = STEP_W'(10);
      3'd2:    step_of = STEP_W'(100);
      3'd3:    step_of = STEP_W'(300);
      3'd4:    step_of = STEP_W'(100);
      3'd5:    step_of = STEP_W'(10);
      3'd6:    step_of = STEP_W'(1);
      default: step_of = STEP_W'(1);
    endcase
  endfunction

endpackage

@@ rtl/core/wbsr_if.sv @@
// Valid/ready channel interfaces for input words and result words.
interface wbsr_in_if;
  import wbsr_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] current_value;
  logic [VAL_W-1:0] target_a_value;
  logic [VAL_W-1:0] target_b_value;
  logic [VAL_W-1:0] target_c_value;

  modport source (output valid, current_value, target_a_value, target_b_value,
                  target_c_value, input ready);
  modport sink (input valid, current_value, target_a_value, target_b_value,
                target_c_value, output ready);
endinterface

interface wbsr_out_if;
  import wbsr_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] refined_value;
  logic [VAL_W-1:0] blended_target;

  modport source (output valid, refined_value, blended_target, input ready);
  modport sink (input valid, refined_value, blended_target, output ready);
endinterface

@@ rtl/core/wbsr_arith.sv @@
// Shared multiply-accumulate and restoring divide unit for the weighted blend.
module wbsr_arith (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wbsr_pkg::arith_ctl_t       ctl_i,
  input  logic [wbsr_pkg::WGT_W-1:0] wgt_i [wbsr_pkg::NUM_TGT],
  input  logic [wbsr_pkg::VAL_W-1:0] tgt_i [wbsr_pkg::NUM_TGT],
  output logic [wbsr_pkg::VAL_W-1:0] blend_o
);
  import wbsr_pkg::*;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [TOT_W-1:0]  tot_q, tot_d;
  logic [VAL_W-1:0]  op_val;
  logic [WGT_W-1:0]  op_wgt;
  logic [PROD_W-1:0] prod;
  logic              fits;

  // Pick the operand pair for this accumulate cycle.
  always_comb begin
    case (ctl_i.sel)
      2'd0: begin
        op_val = tgt_i[0];
        op_wgt = wgt_i[0];
      end
      2'd1: begin
        op_val = tgt_i[1];
        op_wgt = wgt_i[1];
      end
      2'd2: begin
        op_val = tgt_i[2];
        op_wgt = wgt_i[2];
      end
      default: begin
        op_val = '0;
        op_wgt = '0;
      end
    endcase
  end

  assign prod = PROD_W'(op_val) * PROD_W'(op_wgt);
  assign fits = acc_q >= ACC_W'(dvs_q);

  always_comb begin
    acc_d = acc_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    tot_d = tot_q;
    if (ctl_i.clear) begin
      acc_d = '0;
      quo_d = '0;
      tot_d = TOT_W'(wgt_i[0]) + TOT_W'(wgt_i[1]) + TOT_W'(wgt_i[2]);
      dvs_d = {tot_d, {(QUO_W-1){1'b0}}};
    end else if (ctl_i.mac) begin
      acc_d = acc_q + ACC_W'(prod);
    end else if (ctl_i.div) begin
      // One quotient bit per cycle, most significant first.
      if (fits) begin
        acc_d = acc_q - ACC_W'(dvs_q);
      end
      quo_d = {quo_q[QUO_W-2:0], fits};
      dvs_d = dvs_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    tot_q <= tot_d;
  end

  // Zero weight total blends to zero.
  assign blend_o = (tot_q == '0) ? '0 : VAL_W'(quo_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mac |-> !ctl_i.div)
    else $error("accumulate and divide requested together");

endmodule

@@ rtl/core/wbsr_refine.sv @@
// One refinement pass per cycle: approach the blend by the scheduled step, then clamp.
module wbsr_refine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wbsr_pkg::refine_ctl_t      ctl_i,
  input  logic [wbsr_pkg::VAL_W-1:0] load_val_i,
  input  logic [wbsr_pkg::VAL_W-1:0] tgt_i,
  output logic [wbsr_pkg::VAL_W-1:0] cur_o
);
  import wbsr_pkg::*;

  logic [VAL_W-1:0]   cur_q, cur_d;
  logic [SCHED_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0]   diff, step, moved, nxt;
  logic               up;

  assign up    = tgt_i >= cur_q;
  assign diff  = up ? (tgt_i - cur_q) : (cur_q - tgt_i);
  assign step  = VAL_W'(step_of(idx_q));
  assign moved = (diff <= step) ? tgt_i : (up ? (cur_q + step) : (cur_q - step));
  assign nxt   = (moved > VAL_MAX) ? VAL_MAX : moved;

  always_comb begin
    cur_d = cur_q;
    idx_d = idx_q;
    if (ctl_i.load) begin
      cur_d = load_val_i;
      idx_d = '0;
    end else if (ctl_i.step) begin
      cur_d = nxt;
      idx_d = (idx_q == SCHED_W'(SCHED_LEN - 1)) ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign cur_o = cur_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != SCHED_W'(SCHED_LEN))
    else $error("schedule index ran past the end");

endmodule

@@ rtl/core/wbsr_ctrl.sv @@
// Sequencer: accumulate, divide, then any step passes, then hand the word to the output.
module wbsr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_fire_i,
  input  logic                        out_free_i,
  input  logic [wbsr_pkg::ITER_W-1:0] iter_i,
  output logic                        in_ready_o,
  output logic                        out_load_o,
  output wbsr_pkg::arith_ctl_t        arith_o,
  output wbsr_pkg::refine_ctl_t       refine_o
);
  import wbsr_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = cnt_q + 1'b1;

  // Ready depends on the state alone, so the accept strobe never feeds back into it.
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          state_d = ST_MAC;
          cnt_d   = '0;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_inc;
        if (cnt_q == MAC_LAST) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_inc;
        if (cnt_q == DIV_LAST) begin
          state_d = (iter_i == '0) ? ST_DONE : ST_STEP;
          cnt_d   = '0;
        end
      end
      ST_STEP: begin
        cnt_d = cnt_inc;
        if (cnt_inc == CNT_W'(iter_i)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load_o    = 1'b0;
    arith_o       = '0;
    refine_o      = '0;
    arith_o.sel   = cnt_q[1:0];
    case (state_q)
      ST_IDLE: begin
        arith_o.clear  = in_fire_i;
        refine_o.load  = in_fire_i;
      end
      ST_MAC:  arith_o.mac   = 1'b1;
      ST_DIV:  arith_o.div   = 1'b1;
      ST_STEP: refine_o.step = 1'b1;
      ST_DONE: out_load_o    = out_free_i;
      default: out_load_o    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (cnt_q <= MAC_LAST))
    else $error("accumulate phase overran");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == DIV_LAST) |=> (state_q == ST_STEP || state_q == ST_DONE))
    else $error("divide phase did not hand over");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> (state_q == ST_MAC))
    else $error("accepted word did not start the accumulate phase");

endmodule

@@ rtl/core/weighted_blend_stepped_refine.sv @@
// Top level of the weighted blend refiner: config registers, input capture, output register.
//
// Each input word carries one pixel channel in hundredths of a level: a current value and
// three candidate targets, each saturated to 0..25500 on entry. The block blends the targets
// as floor((a*wa + b*wb + c*wc) / (wa + wb + wc)), zero when the weights sum to zero, then
// runs iteration_count refinement passes that move the value toward the blend by at most
// 1, 10, 100, 300, 100, 10, 1 (repeating, restarting with every word) and clamp to 0..25500.
// One word is in flight at a time: the block is ready only while its sequencer is idle. From
// acceptance until its result is loaded into the output register, a word passes through an
// accept step, the single 15x16 multiplier accumulating the three weighted targets one after
// another, fifteen restoring divide steps on the subtractor (one quotient bit each), the
// refinement passes, and a hand-off step.
// The output register holds the result until it is taken; the next word is accepted once
// the result has been loaded, even if it still waits downstream. Write the weight and
// iteration registers (index 0..3: weight_a, weight_b, weight_c, iteration_count) only while
// the block is idle.
module weighted_blend_stepped_refine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wbsr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wbsr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wbsr_in_if.sink                         in_i,
  wbsr_out_if.source                      out_o
);
  import wbsr_pkg::*;

  // Configuration registers.
  logic [WGT_W-1:0]  wgt_q [NUM_TGT];
  logic [ITER_W-1:0] iter_q;

  // Captured targets, saturated on entry.
  logic [VAL_W-1:0]  tgt_q [NUM_TGT];

  // Output register.
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_refined_q;
  logic [VAL_W-1:0]  out_blend_q;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              in_ready;
  arith_ctl_t        arith_ctl;
  refine_ctl_t       refine_ctl;
  logic [VAL_W-1:0]  blend;
  logic [VAL_W-1:0]  refined;

  assign in_fire  = in_i.valid & in_ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Write the addressed register; data above the register width is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wgt_q[0] <= '0;
      wgt_q[1] <= '0;
      wgt_q[2] <= '0;
      iter_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WEIGHT_A:   wgt_q[0] <= cfg_data_i;
        REG_WEIGHT_B:   wgt_q[1] <= cfg_data_i;
        REG_WEIGHT_C:   wgt_q[2] <= cfg_data_i;
        REG_ITER_COUNT: iter_q   <= cfg_data_i[ITER_W-1:0];
        default:        iter_q   <= iter_q;
      endcase
    end
  end

  // Capture the targets for the accumulate phase.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tgt_q[0] <= sat_val(in_i.target_a_value);
      tgt_q[1] <= sat_val(in_i.target_b_value);
      tgt_q[2] <= sat_val(in_i.target_c_value);
    end
  end

  wbsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .iter_i     (iter_q),
    .in_ready_o (in_ready),
    .out_load_o (out_load),
    .arith_o    (arith_ctl),
    .refine_o   (refine_ctl)
  );

  wbsr_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (arith_ctl),
    .wgt_i   (wgt_q),
    .tgt_i   (tgt_q),
    .blend_o (blend)
  );

  wbsr_refine u_refine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (refine_ctl),
    .load_val_i (sat_val(in_i.current_value)),
    .tgt_i      (blend),
    .cur_o      (refined)
  );

  // Hold the finished word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_refined_q <= refined;
      out_blend_q   <= blend;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.refined_value  = out_refined_q;
  assign out_o.blended_target = out_blend_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_refined_q <= VAL_MAX && out_blend_q <= VAL_MAX))
    else $error("result word out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready)
    else $error("ready while a word is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over an untaken word");

endmodule
